// ===== src/jbt_pkg.sv =====
// jbt_pkg: shared types, codes and character constants for the json byte tokenizer
// depends on nothing; used by jbt_rsp_if, the lexer, the result buffer and the top level
`timescale 1ns / 1ps

package jbt_pkg;

   localparam int OUT_BITS  = 24;
   localparam int RES_SLOTS = 3;

   typedef enum logic [3:0] {
      TK_LBRACE   = 4'd0,
      TK_RBRACE   = 4'd1,
      TK_LBRACKET = 4'd2,
      TK_RBRACKET = 4'd3,
      TK_COMMA    = 4'd4,
      TK_COLON    = 4'd5,
      TK_STRING   = 4'd6,
      TK_NUMBER   = 4'd7,
      TK_TRUE     = 4'd8,
      TK_FALSE    = 4'd9,
      TK_NULL     = 4'd10,
      TK_EOF      = 4'd11,
      TK_ERROR    = 4'd12
   } tk_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_UTF8     = 3'd1,
      ERR_UNTERM   = 3'd2,
      ERR_BAD_BOOL = 3'd3,
      ERR_BAD_NULL = 3'd4,
      ERR_UNEXP    = 3'd5
   } err_type;

   typedef struct packed {
      tk_type                kind;
      err_type               err;
      logic [OUT_BITS-1:0]   offset;
      logic [OUT_BITS-1:0]   length;
      logic [OUT_BITS-1:0]   line;
   } jbt_result_type;

   localparam logic [OUT_BITS-1:0] LEN_ONE = OUT_BITS'(1);

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;

   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   // expected keyword character at a given position
   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case ({sel, pos})
         {KW_TRUE, 3'd0}:  ch = "t";
         {KW_TRUE, 3'd1}:  ch = "r";
         {KW_TRUE, 3'd2}:  ch = "u";
         {KW_TRUE, 3'd3}:  ch = "e";
         {KW_FALSE, 3'd0}: ch = "f";
         {KW_FALSE, 3'd1}: ch = "a";
         {KW_FALSE, 3'd2}: ch = "l";
         {KW_FALSE, 3'd3}: ch = "s";
         {KW_FALSE, 3'd4}: ch = "e";
         {KW_NULL, 3'd0}:  ch = "n";
         {KW_NULL, 3'd1}:  ch = "u";
         {KW_NULL, 3'd2}:  ch = "l";
         {KW_NULL, 3'd3}:  ch = "l";
         default:          ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] sel);
      logic [2:0] len;
      len = 3'd4;
      case (sel)
         KW_FALSE: len = 3'd5;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic tk_type kw_kind(input logic [1:0] sel);
      tk_type k;
      k = TK_NULL;
      case (sel)
         KW_TRUE:  k = TK_TRUE;
         KW_FALSE: k = TK_FALSE;
         default:  k = TK_NULL;
      endcase
      return k;
   endfunction

endpackage

// ===== src/jbt_if.sv =====
// jbt_req_if and jbt_rsp_if: valid/ready channels for document bytes and tokens
// depends on jbt_pkg for the token and error code types
`timescale 1ns / 1ps

interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jbt_rsp_if
   import jbt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   tk_type              token_kind;
   err_type             error_code;
   logic [OUT_BITS-1:0] token_offset;
   logic [OUT_BITS-1:0] token_length;
   logic [OUT_BITS-1:0] line_number;
   logic                last_of_run;

   modport source (output valid, output token_kind, output error_code, output token_offset,
                   output token_length, output line_number, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input error_code, input token_offset,
                   input token_length, input line_number, input last_of_run,
                   output ready);
endinterface

// ===== src/jbt_lexer.sv =====
// jbt_lexer: lexer state registers and the combinational step that turns one byte into tokens
// depends on jbt_pkg; drives up to three results per step into jbt_rbuf
`timescale 1ns / 1ps

module jbt_lexer
   import jbt_pkg::*;
#(
   parameter int POSITION_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [7:0]                     data_byte,
   input  logic                           end_of_input,
   output jbt_result_type [RES_SLOTS-1:0] res_list,
   output logic [1:0]                     res_count,
   output logic                           halted
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STRING,
      MODE_INT,
      MODE_DOT,
      MODE_FRAC,
      MODE_MINUS,
      MODE_KEYWORD
   } mode_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic                     escape_ff, escape_in;
   logic [1:0]               utf8_ff, utf8_in;
   logic [1:0]               kw_sel_ff, kw_sel_in;
   logic [2:0]               kw_pos_ff, kw_pos_in;
   logic [POSITION_BITS-1:0] byte_pos_ff, byte_pos_in;
   logic [POSITION_BITS-1:0] start_pos_ff, start_pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic                     halted_ff, halted_in;

   logic [POSITION_BITS-1:0] pos_inc, line_inc, line_put, pos_dec;
   logic [OUT_BITS-1:0]      len_incl, len_excl, len_dot, line_o, pos_o, start_o, dot_o;
   logic                     digit_hit;
   err_type                  kw_err;
   logic [2:0]               kw_len_v;

   jbt_result_type [RES_SLOTS-1:0] res_v;
   logic [1:0]                     n;
   logic                           do_idle;

   function automatic logic [OUT_BITS-1:0] to_out(input logic [POSITION_BITS-1:0] v);
      logic [POSITION_BITS+OUT_BITS-1:0] w;
      w = {{OUT_BITS{1'b0}}, v};
      return w[OUT_BITS-1:0];
   endfunction

   // end is exclusive, result saturates at the counter maximum
   function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS:0]   e,
                                                     input logic [POSITION_BITS-1:0] from);
      logic [POSITION_BITS:0] d;
      d = (e > {1'b0, from}) ? e - {1'b0, from} : '0;
      return d[POSITION_BITS] ? POS_MAX : d[POSITION_BITS-1:0];
   endfunction

   function automatic jbt_result_type mk(input tk_type k, input err_type e,
                                         input logic [OUT_BITS-1:0] off,
                                         input logic [OUT_BITS-1:0] len,
                                         input logic [OUT_BITS-1:0] ln);
      jbt_result_type r;
      r.kind   = k;
      r.err    = e;
      r.offset = off;
      r.length = len;
      r.line   = ln;
      return r;
   endfunction

   assign pos_inc  = (byte_pos_ff == POS_MAX) ? POS_MAX : byte_pos_ff + POS_ONE;
   assign line_inc = (line_ff == POS_MAX) ? POS_MAX : line_ff + POS_ONE;
   assign pos_dec  = byte_pos_ff - POS_ONE;
   assign line_put = (mode_ff == MODE_STRING && data_byte == CH_LF && !end_of_input) ?
                     line_inc : line_ff;

   assign len_incl = to_out(span({1'b0, byte_pos_ff} + {{POSITION_BITS{1'b0}}, 1'b1},
                                 start_pos_ff));
   assign len_excl = to_out(span({1'b0, byte_pos_ff}, start_pos_ff));
   assign len_dot  = to_out(span({1'b0, pos_dec}, start_pos_ff));
   assign line_o   = to_out(line_put);
   assign pos_o    = to_out(byte_pos_ff);
   assign start_o  = to_out(start_pos_ff);
   assign dot_o    = to_out(pos_dec);

   assign digit_hit = data_byte inside {[8'h30:8'h39]};
   assign kw_err    = kw_sel_ff[1] ? ERR_BAD_NULL : ERR_BAD_BOOL;
   assign kw_len_v  = kw_len(kw_sel_ff);

   always_comb begin
      mode_in      = mode_ff;
      escape_in    = escape_ff;
      utf8_in      = utf8_ff;
      kw_sel_in    = kw_sel_ff;
      kw_pos_in    = kw_pos_ff;
      byte_pos_in  = byte_pos_ff;
      start_pos_in = start_pos_ff;
      line_in      = line_ff;
      halted_in    = halted_ff;
      res_v        = '0;
      n            = 2'd0;
      do_idle      = 1'b0;

      if (end_of_input) begin
         if (!halted_ff) begin
            case (mode_ff)
               MODE_STRING: begin
                  res_v[n] = mk(TK_ERROR, ERR_UNTERM, start_o, len_excl, line_o);
                  n = n + 2'd1;
               end
               MODE_INT, MODE_FRAC: begin
                  res_v[n] = mk(TK_NUMBER, ERR_NONE, start_o, len_excl, line_o);
                  n = n + 2'd1;
               end
               MODE_DOT: begin
                  res_v[n] = mk(TK_NUMBER, ERR_NONE, start_o, len_dot, line_o);
                  n = n + 2'd1;
                  res_v[n] = mk(TK_ERROR, ERR_UNEXP, dot_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               MODE_MINUS: begin
                  res_v[n] = mk(TK_ERROR, ERR_UNEXP, start_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               MODE_KEYWORD: begin
                  res_v[n] = mk(TK_ERROR, kw_err, start_o, len_excl, line_o);
                  n = n + 2'd1;
               end
               default: begin
               end
            endcase
         end
         res_v[n] = mk(TK_EOF, ERR_NONE, pos_o, '0, line_o);
         n = n + 2'd1;
         mode_in      = MODE_IDLE;
         escape_in    = 1'b0;
         utf8_in      = 2'd0;
         kw_sel_in    = 2'd0;
         kw_pos_in    = 3'd0;
         byte_pos_in  = '0;
         start_pos_in = '0;
         line_in      = POS_ONE;
         halted_in    = 1'b0;
      end else if (!halted_ff) begin
         case (mode_ff)
            MODE_STRING: begin
               line_in = line_put;
               if (utf8_ff != 2'd0) begin
                  if (data_byte[7:6] != 2'b10) begin
                     res_v[n] = mk(TK_ERROR, ERR_UTF8, start_o, len_incl, line_o);
                     n = n + 2'd1;
                     halted_in = 1'b1;
                     mode_in   = MODE_IDLE;
                  end else begin
                     utf8_in = utf8_ff - 2'd1;
                  end
               end else begin
                  escape_in = 1'b0;
                  if (!data_byte[7]) begin
                     if (!escape_ff) begin
                        if (data_byte == CH_BACKSLASH) begin
                           escape_in = 1'b1;
                        end else if (data_byte == CH_QUOTE) begin
                           res_v[n] = mk(TK_STRING, ERR_NONE, start_o, len_incl, line_o);
                           n = n + 2'd1;
                           mode_in = MODE_IDLE;
                        end
                     end
                  end else if (data_byte[7:5] == 3'b110) begin
                     utf8_in = 2'd1;
                  end else if (data_byte[7:4] == 4'b1110) begin
                     utf8_in = 2'd2;
                  end else if (data_byte[7:3] == 5'b11110) begin
                     utf8_in = 2'd3;
                  end else begin
                     res_v[n] = mk(TK_ERROR, ERR_UTF8, start_o, len_incl, line_o);
                     n = n + 2'd1;
                     halted_in = 1'b1;
                     mode_in   = MODE_IDLE;
                  end
               end
            end
            MODE_INT, MODE_FRAC: begin
               if (!digit_hit) begin
                  if (data_byte == CH_DOT && mode_ff == MODE_INT) begin
                     mode_in = MODE_DOT;
                  end else begin
                     res_v[n] = mk(TK_NUMBER, ERR_NONE, start_o, len_excl, line_o);
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
            end
            MODE_DOT: begin
               if (digit_hit) begin
                  mode_in = MODE_FRAC;
               end else begin
                  res_v[n] = mk(TK_NUMBER, ERR_NONE, start_o, len_dot, line_o);
                  n = n + 2'd1;
                  res_v[n] = mk(TK_ERROR, ERR_UNEXP, dot_o, LEN_ONE, line_o);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in   = MODE_IDLE;
               end
            end
            MODE_MINUS: begin
               if (digit_hit) begin
                  mode_in = MODE_INT;
               end else begin
                  res_v[n] = mk(TK_ERROR, ERR_UNEXP, start_o, LEN_ONE, line_o);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in   = MODE_IDLE;
               end
            end
            MODE_KEYWORD: begin
               if (kw_pos_ff < kw_len_v && data_byte == kw_char(kw_sel_ff, kw_pos_ff)) begin
                  kw_pos_in = kw_pos_ff + 3'd1;
                  if (kw_pos_ff + 3'd1 == kw_len_v) begin
                     res_v[n] = mk(kw_kind(kw_sel_ff), ERR_NONE, start_o, len_incl, line_o);
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  res_v[n] = mk(TK_ERROR, kw_err, start_o, len_incl, line_o);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in   = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase

         // byte seen with no token open
         if (do_idle) begin
            case (data_byte)
               CH_SPACE, CH_TAB, CH_CR: begin
               end
               CH_LF: line_in = line_inc;
               CH_LBRACE: begin
                  res_v[n] = mk(TK_LBRACE, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_RBRACE: begin
                  res_v[n] = mk(TK_RBRACE, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_LBRACKET: begin
                  res_v[n] = mk(TK_LBRACKET, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_RBRACKET: begin
                  res_v[n] = mk(TK_RBRACKET, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_COMMA: begin
                  res_v[n] = mk(TK_COMMA, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_COLON: begin
                  res_v[n] = mk(TK_COLON, ERR_NONE, pos_o, LEN_ONE, line_o);
                  n = n + 2'd1;
               end
               CH_QUOTE: begin
                  start_pos_in = byte_pos_ff;
                  mode_in      = MODE_STRING;
                  escape_in    = 1'b0;
                  utf8_in      = 2'd0;
               end
               CH_MINUS: begin
                  start_pos_in = byte_pos_ff;
                  mode_in      = MODE_MINUS;
               end
               CH_T, CH_F, CH_N: begin
                  start_pos_in = byte_pos_ff;
                  mode_in      = MODE_KEYWORD;
                  kw_pos_in    = 3'd1;
                  if (data_byte == CH_T) begin
                     kw_sel_in = KW_TRUE;
                  end else if (data_byte == CH_F) begin
                     kw_sel_in = KW_FALSE;
                  end else begin
                     kw_sel_in = KW_NULL;
                  end
               end
               default: begin
                  start_pos_in = byte_pos_ff;
                  if (digit_hit) begin
                     mode_in = MODE_INT;
                  end else begin
                     res_v[n] = mk(TK_ERROR, ERR_UNEXP, pos_o, LEN_ONE, line_o);
                     n = n + 2'd1;
                     halted_in = 1'b1;
                     mode_in   = MODE_IDLE;
                  end
               end
            endcase
         end
         byte_pos_in = pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         escape_ff    <= 1'b0;
         utf8_ff      <= 2'd0;
         kw_sel_ff    <= 2'd0;
         kw_pos_ff    <= 3'd0;
         byte_pos_ff  <= '0;
         start_pos_ff <= '0;
         line_ff      <= POS_ONE;
         halted_ff    <= 1'b0;
      end else if (step) begin
         mode_ff      <= mode_in;
         escape_ff    <= escape_in;
         utf8_ff      <= utf8_in;
         kw_sel_ff    <= kw_sel_in;
         kw_pos_ff    <= kw_pos_in;
         byte_pos_ff  <= byte_pos_in;
         start_pos_ff <= start_pos_in;
         line_ff      <= line_in;
         halted_ff    <= halted_in;
      end
   end

   assign res_list  = res_v;
   assign res_count = n;
   assign halted    = halted_ff;

endmodule

// ===== src/jbt_rbuf.sv =====
// jbt_rbuf: three-slot result register for one step's tokens; drains one a cycle when out_ready
// depends on jbt_pkg for the result record
`timescale 1ns / 1ps

module jbt_rbuf
   import jbt_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [1:0]                     load_count,
   input  jbt_result_type [RES_SLOTS-1:0] load_res,
   input  logic                           out_ready,
   output logic                           out_valid,
   output jbt_result_type                 out_res,
   output logic                           out_last,
   output logic                           can_load
);

   jbt_result_type [RES_SLOTS-1:0] slot_ff;
   logic [1:0]                     count_ff;
   logic                           pop;

   assign pop      = (count_ff != 2'd0) && out_ready;
   // free when empty or once the last waiting token leaves in this cycle
   assign can_load = (count_ff == 2'd0) || (count_ff == 2'd1 && out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load) begin
         count_ff <= load_count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_res   = slot_ff[0];
   assign out_last  = (count_ff == 2'd1);

endmodule

// ===== src/json_byte_tokenizer_core.sv =====
// json_byte_tokenizer_core: top level of the json byte tokenizer
// depends on jbt_pkg, jbt_if (jbt_req_if, jbt_rsp_if), jbt_lexer and jbt_rbuf
//
//   channel  | direction | carries
//   ---------+-----------+------------------------------------------------------------
//   req_bus  | in        | data_byte, end_of_input: one document byte per request
//   rsp_bus  | out       | token_kind, error_code, token_offset, token_length,
//            |           | line_number, last_of_run: one token per transfer
//
// a request is registered, then stepped through the lexer into the result slots
// one byte per cycle while rsp_bus is ready and each byte gives at most one token; a byte
// giving k tokens holds the input until its last token leaves, as the slots drain one a cycle
// reset (synchronous, active high) clears the lexer to idle, line 1, position 0
// rsp_bus stalls back up through the result slots and the input register to req_bus.ready
`timescale 1ns / 1ps

module json_byte_tokenizer_core
   import jbt_pkg::*;
#(
   parameter int POSITION_BITS = 24
) (
   input logic    clock,
   input logic    reset,
   jbt_req_if.sink   req_bus,
   jbt_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       advance;
   logic       can_load;
   logic       lexer_halted;

   jbt_result_type [RES_SLOTS-1:0] step_res;
   logic [1:0]                     step_count;
   jbt_result_type                 head_res;

   assign advance       = in_valid_ff && can_load;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_eoi_ff  <= req_bus.end_of_input;
      end
   end

   jbt_lexer #(
      .POSITION_BITS (POSITION_BITS)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .res_list     (step_res),
      .res_count    (step_count),
      .halted       (lexer_halted)
   );

   jbt_rbuf u_rbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_count (step_count),
      .load_res   (step_res),
      .out_ready  (rsp_bus.ready),
      .out_valid  (rsp_bus.valid),
      .out_res    (head_res),
      .out_last   (rsp_bus.last_of_run),
      .can_load   (can_load)
   );

   assign rsp_bus.token_kind   = head_res.kind;
   assign rsp_bus.error_code   = head_res.err;
   assign rsp_bus.token_offset = head_res.offset;
   assign rsp_bus.token_length = head_res.length;
   assign rsp_bus.line_number  = head_res.line;

   // end of input always closes its run with the eof token
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.token_kind == TK_EOF |-> rsp_bus.last_of_run && rsp_bus.token_length == '0)
      else $error("eof token not last of run or with nonzero length");

   // error code only travels with an error token
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.token_kind != TK_ERROR |-> rsp_bus.error_code == ERR_NONE)
      else $error("error code on a non-error token");

   // a halted lexer produces nothing for ordinary bytes
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && lexer_halted && !in_eoi_ff |-> step_count == 2'd0)
      else $error("tokens produced while halted");

   // the lexer becomes halted only through an error token in the same step
   a_halt_cause: assert property (@(posedge clock) disable iff (reset)
      advance && !lexer_halted ##1 lexer_halted |-> $past(step_count) != 2'd0)
      else $error("halt without an error token");

endmodule
